[sv/dcb_pkg.sv]
// Shared constants, codes and table generators for the double-sided Crystal Ball evaluator.
`default_nettype none

package dcb_pkg;

    localparam int unsigned EXP_TABLE_BITS_DEF = 10;
    localparam int unsigned LOG_TABLE_BITS_DEF = 10;

    // Fraction bits of the internal exponent and normalized offset.
    localparam int unsigned QF = 24;

    // Quotient bits of the offset division and of the tail ratio division.
    localparam int unsigned DIV1_N = 56;
    localparam int unsigned DIV2_N = 63;

    localparam logic [63:0] HALF_LOG2E_Q32 = 64'd3098164009;
    localparam logic [63:0] LN2_Q31        = 64'd1488522236;
    localparam logic [63:0] LOG2E_Q30      = 64'd1549082005;

    localparam logic [31:0] RST_PEAK  = 32'd0;
    localparam logic [31:0] RST_WIDTH = 32'd65536;
    localparam logic [23:0] RST_ALPHA = 24'd65536;
    localparam logic [23:0] RST_ORDER = 24'd131072;

    typedef enum logic [1:0] {
        REGION_CORE = 2'd0,
        REGION_LOW  = 2'd1,
        REGION_HIGH = 2'd2
    } t_region;

    typedef enum logic [2:0] {
        CFG_PEAK     = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_LO_ALPHA = 3'd2,
        CFG_LO_ORDER = 3'd3,
        CFG_HI_ALPHA = 3'd4,
        CFG_HI_ORDER = 3'd5
    } t_cfg_idx;

    // Unsigned quotient by shift and subtract; only used while the tables are built.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry idx of 2^(-idx/2^bits) in Q.31, from a truncated Taylor series of exp(-y).
    function automatic logic [31:0] exp_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] y;
        logic [63:0] term;
        longint      sum;
        int unsigned k;
        y    = (64'(idx) * LN2_Q31) >> bits;
        term = 64'd1 << 31;
        sum  = 64'sd2147483648;
        for (k = 1; k <= 24; k++) begin
            term = div_u64((term * y) >> 31, 64'(k));
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return sum[31:0];
    endfunction

    // Entry idx of log2(1 + idx/2^bits) in Q.24, from the atanh series.
    function automatic logic [31:0] log_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] res;
        int unsigned k;
        z   = div_u64(64'(idx) << 31, (64'd2 << bits) + 64'(idx));
        z2  = (z * z) >> 31;
        pw  = z;
        acc = '0;
        for (k = 0; k < 16; k++) begin
            acc = acc + div_u64(pw, 64'(2 * k + 1));
            pw  = (pw * z2) >> 31;
        end
        res = (((64'd2 * acc) * LOG2E_Q30) + (64'd1 << 36)) >> 37;
        return res[31:0];
    endfunction

endpackage

`default_nettype wire

[sv/double_sided_crystal_ball_eval.sv]
// Pipelined evaluator of the unnormalized double-sided Crystal Ball shape.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------
//  sample   | i_in_valid  / o_in_ready     | i_mass_sample
//  result   | o_out_valid / i_out_ready    | o_density, o_region
//  config   | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One request enters per cycle while the result queue has room.
// The two dividers produce one quotient bit per stage (56 and 63 stages).
// All stages advance together while the two-entry result queue has room.
// Reset clears the valid bits, the queue and the configuration registers to their default values.
`default_nettype none

module double_sided_crystal_ball_eval #(
    parameter int unsigned EXP_TABLE_BITS = dcb_pkg::EXP_TABLE_BITS_DEF,
    parameter int unsigned LOG_TABLE_BITS = dcb_pkg::LOG_TABLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_mass_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_density,
    output logic [1:0]       o_region,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned EB    = EXP_TABLE_BITS;
    localparam int unsigned LB    = LOG_TABLE_BITS;
    localparam int unsigned EXP_N = 2 ** EB;
    localparam int unsigned LOG_N = 2 ** LB;
    localparam int unsigned SH    = dcb_pkg::QF - EB;
    localparam int unsigned PW    = 32 + SH;
    localparam int unsigned N1    = dcb_pkg::DIV1_N;
    localparam int unsigned N2    = dcb_pkg::DIV2_N;
    localparam int unsigned NS    = 6;
    localparam int unsigned LOG_W = 25;

    // Configuration registers.
    logic [31:0] r_cfg_m0;
    logic [31:0] r_cfg_sig;
    logic [23:0] r_cfg_alo;
    logic [23:0] r_cfg_nlo;
    logic [23:0] r_cfg_ahi;
    logic [23:0] r_cfg_nhi;
    logic [31:0] w_sig;
    logic [23:0] w_nlo;
    logic [23:0] w_nhi;

    logic w_adv;

    // Constant tables.
    logic [31:0]      exp_rom [0:EXP_N];
    logic [LOG_W-1:0] log_rom [0:LOG_N];

    // Offset stage and first divider.
    logic signed [32:0] w_diff;
    logic [32:0]        w_ndiff;
    logic [31:0]        w_mag;
    logic               r_d1_v   [0:N1];
    logic               r_d1_neg [0:N1];
    logic [N1-1:0]      r_d1_num [0:N1];
    logic [31:0]        r_d1_rem [0:N1];

    // Classification.
    logic [N1-1:0]      w_tabs;
    logic [23:0]        w_ca;
    logic [31:0]        w_cax;
    logic               w_ctail;
    logic               r_c_v;
    dcb_pkg::t_region   r_c_reg;
    logic [31:0]        r_c_x;
    logic [N1-1:0]      r_c_u;

    // Products.
    logic [23:0]        w_m1_a;
    logic [63:0]        w_m1_sq;
    logic               r_m1_v;
    dcb_pkg::t_region   r_m1_reg;
    logic [31:0]        r_m1_sq;
    logic [55:0]        r_m1_lo;
    logic [23:0]        r_m1_uhi;
    logic [23:0]        w_m2_a;
    logic [63:0]        w_m2_gp;
    logic               r_m2_v;
    dcb_pkg::t_region   r_m2_reg;
    logic [47:0]        r_m2_hi;
    logic [55:0]        r_m2_lo;
    logic [39:0]        r_m2_g;

    // Scaling of the tail product.
    logic [4:0]         w_b_s;
    logic               r_b_v;
    dcb_pkg::t_region   r_b_reg;
    logic [79:0]        r_b_p;
    logic [4:0]         r_b_s;
    logic [39:0]        r_b_g;
    logic [79:0]        w_ps;

    // Second divider.
    logic               r_d2_v   [0:N2];
    dcb_pkg::t_region   r_d2_reg [0:N2];
    logic [N2-1:0]      r_d2_num [0:N2];
    logic [23:0]        r_d2_rem [0:N2];
    logic [4:0]         r_d2_s   [0:N2];
    logic [39:0]        r_d2_g   [0:N2];

    // Normalization for the logarithm.
    logic [63:0]        w_t2;
    logic [63:0]        w_r;
    logic               r_n_v   [0:NS];
    dcb_pkg::t_region   r_n_reg [0:NS];
    logic [63:0]        r_n_y   [0:NS];
    logic [5:0]         r_n_z   [0:NS];
    logic [4:0]         r_n_s   [0:NS];
    logic [39:0]        r_n_g   [0:NS];

    // Logarithm.
    logic [63:0]        w_ly;
    logic [LB-1:0]      w_lidx;
    logic [LB:0]        w_lidx1;
    logic               r_l1_v;
    dcb_pkg::t_region   r_l1_reg;
    logic [LOG_W-1:0]   r_l1_t0;
    logic [LOG_W-1:0]   r_l1_t1;
    logic [23:0]        r_l1_rem;
    logic [5:0]         r_l1_e;
    logic [4:0]         r_l1_s;
    logic [39:0]        r_l1_g;
    logic [LOG_W-1:0]   w_l2_d;
    logic [48:0]        w_l2_p;
    logic               r_l2_v;
    dcb_pkg::t_region   r_l2_reg;
    logic [LOG_W-1:0]   r_l2_t0;
    logic [LOG_W-1:0]   r_l2_ip;
    logic [5:0]         r_l2_e;
    logic [4:0]         r_l2_s;
    logic [39:0]        r_l2_g;
    logic [31:0]        w_l3_lg;
    logic [31:0]        w_l3_lr;
    logic               r_l3_v;
    dcb_pkg::t_region   r_l3_reg;
    logic [30:0]        r_l3_lr;
    logic [39:0]        r_l3_g;

    // Exponent assembly.
    logic [23:0]        w_m3_n;
    logic [54:0]        w_m3_p;
    logic               r_m3_v;
    dcb_pkg::t_region   r_m3_reg;
    logic [38:0]        r_m3_nl;
    logic [39:0]        r_m3_g;
    logic               r_f_v;
    dcb_pkg::t_region   r_f_reg;
    logic [40:0]        r_f_e;

    // Power of two.
    logic [EB-1:0]      w_eidx;
    logic [EB:0]        w_eidx1;
    logic               r_x1_v;
    dcb_pkg::t_region   r_x1_reg;
    logic [31:0]        r_x1_e0;
    logic [31:0]        r_x1_e1;
    logic [SH-1:0]      r_x1_rm;
    logic [4:0]         r_x1_k;
    logic               r_x1_zero;
    logic [31:0]        w_x2_d;
    logic [PW-1:0]      w_x2_p;
    logic               r_x2_v;
    dcb_pkg::t_region   r_x2_reg;
    logic [31:0]        r_x2_e0;
    logic [31:0]        r_x2_p;
    logic [4:0]         r_x2_k;
    logic               r_x2_zero;
    logic [31:0]        w_x3_v;
    logic [31:0]        w_dens;

    // Result queue.
    logic [1:0]         r_fq_cnt;
    logic [1:0]         n_fq_cnt;
    logic [31:0]        r_fq_dens [0:1];
    dcb_pkg::t_region   r_fq_reg  [0:1];
    logic               w_push;
    logic               w_pop;

    // ---------------------------------------------------------------- tables
    for (genvar gi = 0; gi <= int'(EXP_N); gi++) begin : g_exp_rom
        localparam logic [31:0] VAL = dcb_pkg::exp_entry(gi, EB);
        assign exp_rom[gi] = VAL;
    end

    for (genvar gi = 0; gi <= int'(LOG_N); gi++) begin : g_log_rom
        localparam logic [31:0] VAL = dcb_pkg::log_entry(gi, LB);
        assign log_rom[gi] = VAL[LOG_W-1:0];
    end

    // --------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_m0  <= dcb_pkg::RST_PEAK;
            r_cfg_sig <= dcb_pkg::RST_WIDTH;
            r_cfg_alo <= dcb_pkg::RST_ALPHA;
            r_cfg_nlo <= dcb_pkg::RST_ORDER;
            r_cfg_ahi <= dcb_pkg::RST_ALPHA;
            r_cfg_nhi <= dcb_pkg::RST_ORDER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dcb_pkg::CFG_PEAK:     r_cfg_m0  <= i_cfg_data;
                dcb_pkg::CFG_WIDTH:    r_cfg_sig <= i_cfg_data;
                dcb_pkg::CFG_LO_ALPHA: r_cfg_alo <= i_cfg_data[23:0];
                dcb_pkg::CFG_LO_ORDER: r_cfg_nlo <= i_cfg_data[23:0];
                dcb_pkg::CFG_HI_ALPHA: r_cfg_ahi <= i_cfg_data[23:0];
                dcb_pkg::CFG_HI_ORDER: r_cfg_nhi <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // A zero width or order behaves as one LSB.
    assign w_sig = (r_cfg_sig == '0) ? 32'd1 : r_cfg_sig;
    assign w_nlo = (r_cfg_nlo == '0) ? 24'd1 : r_cfg_nlo;
    assign w_nhi = (r_cfg_nhi == '0) ? 24'd1 : r_cfg_nhi;

    // The whole pipeline moves while the result queue has a free slot.
    assign w_adv      = (r_fq_cnt != 2'd2);
    assign o_in_ready = w_adv;

    // ---------------------------------------------------------- offset stage
    assign w_diff  = $signed({i_mass_sample[31], i_mass_sample})
                   - $signed({r_cfg_m0[31], r_cfg_m0});
    assign w_ndiff = -w_diff;
    assign w_mag   = w_diff[32] ? w_ndiff[31:0] : w_diff[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_d1_v[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1_neg[0] <= w_diff[32];
            r_d1_num[0] <= {w_mag, 24'd0};
            r_d1_rem[0] <= '0;
        end
    end

    // Restoring division |m - m0| * 2^24 / sigma, one quotient bit per stage.
    for (genvar j = 0; j < int'(N1); j++) begin : g_div1
        logic [32:0] t;
        logic [32:0] dif;
        logic        ge;
        assign t   = {r_d1_rem[j], r_d1_num[j][N1-1]};
        assign dif = t - {1'b0, w_sig};
        assign ge  = (t >= {1'b0, w_sig});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_d1_v[j+1] <= r_d1_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d1_neg[j+1] <= r_d1_neg[j];
                r_d1_num[j+1] <= {r_d1_num[j][N1-2:0], ge};
                r_d1_rem[j+1] <= ge ? dif[31:0] : t[31:0];
            end
        end
    end

    // ------------------------------------------------------------- classify
    assign w_tabs  = r_d1_num[N1];
    assign w_ca    = r_d1_neg[N1] ? r_cfg_alo : r_cfg_ahi;
    assign w_cax   = {w_ca, 8'd0};
    assign w_ctail = (w_tabs > {{(N1-32){1'b0}}, w_cax});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (!w_ctail) begin
                r_c_reg <= dcb_pkg::REGION_CORE;
            end else if (r_d1_neg[N1]) begin
                r_c_reg <= dcb_pkg::REGION_LOW;
            end else begin
                r_c_reg <= dcb_pkg::REGION_HIGH;
            end
            r_c_x <= w_ctail ? w_cax : w_tabs[31:0];
            r_c_u <= w_tabs - {{(N1-32){1'b0}}, w_cax};
        end
    end

    // ------------------------------------------------------------- products
    assign w_m1_a  = (r_c_reg == dcb_pkg::REGION_LOW) ? r_cfg_alo : r_cfg_ahi;
    assign w_m1_sq = 64'(r_c_x) * 64'(r_c_x);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_reg <= r_c_reg;
            r_m1_sq  <= w_m1_sq[63:32];
            r_m1_lo  <= 56'(r_c_u[31:0]) * 56'(w_m1_a);
            r_m1_uhi <= r_c_u[N1-1:32];
        end
    end

    assign w_m2_a  = (r_m1_reg == dcb_pkg::REGION_LOW) ? r_cfg_alo : r_cfg_ahi;
    assign w_m2_gp = 64'(r_m1_sq) * dcb_pkg::HALF_LOG2E_Q32;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_reg <= r_m1_reg;
            r_m2_hi  <= 48'(r_m1_uhi) * 48'(w_m2_a);
            r_m2_lo  <= r_m1_lo;
            r_m2_g   <= w_m2_gp[63:24];
        end
    end

    // The scale s is the number of bits the upper partial product reaches past bit 29.
    always_comb begin
        w_b_s = '0;
        for (int i = 0; i < 18; i++) begin
            if (r_m2_hi[30+i]) begin
                w_b_s = 5'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_reg <= r_m2_reg;
            r_b_p   <= {r_m2_hi, 32'd0} + {24'd0, r_m2_lo};
            r_b_s   <= w_b_s;
            r_b_g   <= r_m2_g;
        end
    end

    assign w_ps = r_b_p >> r_b_s;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d2_reg[0] <= r_b_reg;
            r_d2_num[0] <= w_ps[N2-1:0];
            r_d2_rem[0] <= '0;
            r_d2_s[0]   <= r_b_s;
            r_d2_g[0]   <= r_b_g;
        end
    end

    // Restoring division of the scaled tail product by the order.
    for (genvar j = 0; j < int'(N2); j++) begin : g_div2
        logic [23:0] nn;
        logic [24:0] t;
        logic [24:0] dif;
        logic        ge;
        assign nn  = (r_d2_reg[j] == dcb_pkg::REGION_LOW) ? w_nlo : w_nhi;
        assign t   = {r_d2_rem[j], r_d2_num[j][N2-1]};
        assign dif = t - {1'b0, nn};
        assign ge  = (t >= {1'b0, nn});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_d2_v[j+1] <= r_d2_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d2_reg[j+1] <= r_d2_reg[j];
                r_d2_num[j+1] <= {r_d2_num[j][N2-2:0], ge};
                r_d2_rem[j+1] <= ge ? dif[23:0] : t[23:0];
                r_d2_s[j+1]   <= r_d2_s[j];
                r_d2_g[j+1]   <= r_d2_g[j];
            end
        end
    end

    // -------------------------------------------------------- normalization
    assign w_t2 = (64'd1 << dcb_pkg::QF) >> r_d2_s[N2];
    assign w_r  = {1'b0, r_d2_num[N2]} + w_t2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_reg[0] <= r_d2_reg[N2];
            r_n_y[0]   <= w_r;
            r_n_z[0]   <= '0;
            r_n_s[0]   <= r_d2_s[N2];
            r_n_g[0]   <= r_d2_g[N2];
        end
    end

    // Each stage tests one bit of the leading-zero count, widest step first.
    for (genvar k = 0; k < int'(NS); k++) begin : g_norm
        localparam int unsigned W = 32 >> k;
        logic top_zero;
        assign top_zero = (r_n_y[k][63 -: W] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_n_v[k+1] <= r_n_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_n_reg[k+1] <= r_n_reg[k];
                r_n_y[k+1]   <= top_zero ? (r_n_y[k] << W) : r_n_y[k];
                r_n_z[k+1]   <= top_zero ? (r_n_z[k] | 6'(W)) : r_n_z[k];
                r_n_s[k+1]   <= r_n_s[k];
                r_n_g[k+1]   <= r_n_g[k];
            end
        end
    end

    // ------------------------------------------------------------ logarithm
    assign w_ly    = r_n_y[NS];
    assign w_lidx  = w_ly[62 -: LB];
    assign w_lidx1 = {1'b0, w_lidx} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l1_reg <= r_n_reg[NS];
            r_l1_t0  <= log_rom[{1'b0, w_lidx}];
            r_l1_t1  <= log_rom[w_lidx1];
            r_l1_rem <= w_ly[62-LB -: 24];
            r_l1_e   <= 6'd63 - r_n_z[NS];
            r_l1_s   <= r_n_s[NS];
            r_l1_g   <= r_n_g[NS];
        end
    end

    assign w_l2_d = r_l1_t1 - r_l1_t0;
    assign w_l2_p = 49'(w_l2_d) * 49'(r_l1_rem);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l2_reg <= r_l1_reg;
            r_l2_t0  <= r_l1_t0;
            r_l2_ip  <= w_l2_p[48:24];
            r_l2_e   <= r_l1_e;
            r_l2_s   <= r_l1_s;
            r_l2_g   <= r_l1_g;
        end
    end

    // log2 of the ratio plus the scale, less 24, floored at zero.
    assign w_l3_lg = {2'd0, r_l2_e, 24'd0} + 32'(r_l2_t0) + 32'(r_l2_ip)
                   + {3'd0, r_l2_s, 24'd0};
    assign w_l3_lr = (w_l3_lg >= (32'd24 << dcb_pkg::QF))
                   ? (w_l3_lg - (32'd24 << dcb_pkg::QF)) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l3_reg <= r_l2_reg;
            r_l3_lr  <= w_l3_lr[30:0];
            r_l3_g   <= r_l2_g;
        end
    end

    // ----------------------------------------------------- exponent assembly
    assign w_m3_n = (r_l3_reg == dcb_pkg::REGION_LOW) ? w_nlo : w_nhi;
    assign w_m3_p = 55'(w_m3_n) * 55'(r_l3_lr);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_reg <= r_l3_reg;
            r_m3_nl  <= w_m3_p[54:16];
            r_m3_g   <= r_l3_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_reg <= r_m3_reg;
            r_f_e   <= (r_m3_reg == dcb_pkg::REGION_CORE)
                     ? {1'b0, r_m3_g} : ({1'b0, r_m3_g} + {2'd0, r_m3_nl});
        end
    end

    // ---------------------------------------------------------- power of two
    assign w_eidx  = r_f_e[23 -: EB];
    assign w_eidx1 = {1'b0, w_eidx} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x1_reg  <= r_f_reg;
            r_x1_e0   <= exp_rom[{1'b0, w_eidx}];
            r_x1_e1   <= exp_rom[w_eidx1];
            r_x1_rm   <= r_f_e[SH-1:0];
            r_x1_k    <= r_f_e[28:24];
            r_x1_zero <= (r_f_e[40:29] != '0);
        end
    end

    assign w_x2_d = r_x1_e0 - r_x1_e1;
    assign w_x2_p = PW'(w_x2_d) * PW'(r_x1_rm);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x2_reg  <= r_x1_reg;
            r_x2_e0   <= r_x1_e0;
            r_x2_p    <= w_x2_p[PW-1:SH];
            r_x2_k    <= r_x1_k;
            r_x2_zero <= r_x1_zero;
        end
    end

    assign w_x3_v = r_x2_e0 - r_x2_p;
    assign w_dens = r_x2_zero ? 32'd0 : (w_x3_v >> r_x2_k);

    // Valid bits of the single stages between and after the arrays, and of the array inputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v     <= 1'b0;
            r_m1_v    <= 1'b0;
            r_m2_v    <= 1'b0;
            r_b_v     <= 1'b0;
            r_d2_v[0] <= 1'b0;
            r_n_v[0]  <= 1'b0;
            r_l1_v    <= 1'b0;
            r_l2_v    <= 1'b0;
            r_l3_v    <= 1'b0;
            r_m3_v    <= 1'b0;
            r_f_v     <= 1'b0;
            r_x1_v    <= 1'b0;
            r_x2_v    <= 1'b0;
        end else if (w_adv) begin
            r_c_v     <= r_d1_v[N1];
            r_m1_v    <= r_c_v;
            r_m2_v    <= r_m1_v;
            r_b_v     <= r_m2_v;
            r_d2_v[0] <= r_b_v;
            r_n_v[0]  <= r_d2_v[N2];
            r_l1_v    <= r_n_v[NS];
            r_l2_v    <= r_l1_v;
            r_l3_v    <= r_l2_v;
            r_m3_v    <= r_l3_v;
            r_f_v     <= r_m3_v;
            r_x1_v    <= r_f_v;
            r_x2_v    <= r_x1_v;
        end
    end

    // ---------------------------------------------------------- result queue
    assign w_push = r_x2_v && w_adv;
    assign w_pop  = o_out_valid && i_out_ready;

    always_comb begin
        n_fq_cnt = r_fq_cnt;
        if (w_push && !w_pop) begin
            n_fq_cnt = r_fq_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fq_cnt = r_fq_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fq_cnt <= '0;
        end else begin
            r_fq_cnt <= n_fq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (r_fq_cnt == 2'd2)) begin
            r_fq_dens[0] <= r_fq_dens[1];
            r_fq_reg[0]  <= r_fq_reg[1];
        end
        if (w_push) begin
            if ((r_fq_cnt == 2'd0) || ((r_fq_cnt == 2'd1) && w_pop)) begin
                r_fq_dens[0] <= w_dens;
                r_fq_reg[0]  <= r_x2_reg;
            end else begin
                r_fq_dens[1] <= w_dens;
                r_fq_reg[1]  <= r_x2_reg;
            end
        end
    end

    assign o_out_valid = (r_fq_cnt != 2'd0);
    assign o_density   = r_fq_dens[0];
    assign o_region    = r_fq_reg[0];

endmodule

`default_nettype wire
